[hw/rtl/dgp_pkg.sv]
package dgp_pkg;

    localparam int PIX_W   = 8;
    localparam int ERR_W   = 10;
    localparam int PRED_W  = 11;
    localparam int CFG_W_W = 13;
    localparam int CFG_H_W = 16;

    localparam int INIT_PRED  = 128;
    localparam int GAP_T_HI   = 80;
    localparam int GAP_T_MID  = 32;
    localparam int GAP_T_LO   = 8;
    localparam int MIN_WIDTH  = 3;
    localparam int MIN_HEIGHT = 2;

    // register indexes on the configuration port
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_RULE   = 2'd2;

    localparam logic [CFG_W_W-1:0] RST_WIDTH  = 13'd512;
    localparam logic [CFG_H_W-1:0] RST_HEIGHT = 16'd512;

    typedef enum logic [1:0] {
        RULE_WEST  = 2'd0,
        RULE_NORTH = 2'd1,
        RULE_MEAN  = 2'd2,
        RULE_GAP   = 2'd3
    } t_rule;

    typedef logic [PIX_W-1:0] t_pix;

    typedef struct packed {
        t_pix w;
        t_pix n;
        t_pix ww;
        t_pix nw;
        t_pix nn;
        t_pix ne;
        t_pix nne;
    } t_nbr;

    typedef struct packed {
        logic first;   // row 0, column 0
        logic row0;    // all of row 0
        logic border;  // row 1, columns 0 and 1, last column
    } t_pos;

endpackage

[hw/rtl/dgp_ram.sv]
module dgp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

[hw/rtl/dgp_predict.sv]
module dgp_predict (
    input  dgp_pkg::t_nbr                     i_nbr,
    input  dgp_pkg::t_pos                     i_pos,
    input  dgp_pkg::t_rule                    i_rule,
    output logic signed [dgp_pkg::PRED_W-1:0] o_pred
);

    localparam logic signed [10:0] T_HI  = 11'(dgp_pkg::GAP_T_HI);
    localparam logic signed [10:0] T_MID = 11'(dgp_pkg::GAP_T_MID);
    localparam logic signed [10:0] T_LO  = 11'(dgp_pkg::GAP_T_LO);

    function automatic logic [7:0] absd(input logic [7:0] a, input logic [7:0] b);
        absd = (a > b) ? a - b : b - a;
    endfunction

    logic [9:0]         dh;
    logic [9:0]         dv;
    logic signed [10:0] vh;
    logic signed [10:0] hv;
    logic [8:0]         sum_wn;
    logic signed [8:0]  d_ne;
    logic signed [8:0]  d_adj;
    logic signed [8:0]  q_ne;
    logic signed [10:0] p;
    logic signed [10:0] p_adj;
    logic signed [10:0] p_half;
    logic signed [11:0] p3;
    logic signed [11:0] p3_adj;
    logic signed [11:0] p3_q;
    logic signed [10:0] w_ext;
    logic signed [10:0] n_ext;
    logic signed [10:0] w2;
    logic signed [10:0] n2;
    logic signed [10:0] w4;
    logic signed [10:0] n4;
    logic signed [10:0] gap;

    always_comb begin
        dh = 10'(absd(i_nbr.w, i_nbr.ww)) + 10'(absd(i_nbr.n, i_nbr.nw))
           + 10'(absd(i_nbr.ne, i_nbr.n));
        dv = 10'(absd(i_nbr.w, i_nbr.nw)) + 10'(absd(i_nbr.n, i_nbr.nn))
           + 10'(absd(i_nbr.ne, i_nbr.nne));
        vh = $signed({1'b0, dv}) - $signed({1'b0, dh});
        hv = $signed({1'b0, dh}) - $signed({1'b0, dv});

        // (w + n) / 2 + (ne - nw) / 4, truncating toward zero
        sum_wn = 9'(i_nbr.w) + 9'(i_nbr.n);
        d_ne   = $signed({1'b0, i_nbr.ne}) - $signed({1'b0, i_nbr.nw});
        d_adj  = d_ne + (d_ne[8] ? 9'sd3 : 9'sd0);
        q_ne   = d_adj >>> 2;
        p      = $signed({3'b000, sum_wn[8:1]}) + $signed({{2{q_ne[8]}}, q_ne});

        p_adj  = p + (p[10] ? 11'sd1 : 11'sd0);
        p_half = p_adj >>> 1;
        p3     = $signed({p[10], p}) + $signed({p, 1'b0});
        p3_adj = p3 + (p3[11] ? 12'sd3 : 12'sd0);
        p3_q   = p3_adj >>> 2;

        w_ext = $signed({3'b000, i_nbr.w});
        n_ext = $signed({3'b000, i_nbr.n});
        w2    = $signed({4'b0000, i_nbr.w[7:1]});
        n2    = $signed({4'b0000, i_nbr.n[7:1]});
        w4    = $signed({5'b00000, i_nbr.w[7:2]});
        n4    = $signed({5'b00000, i_nbr.n[7:2]});

        if (vh > T_HI) begin
            gap = w_ext;
        end else if (hv > T_HI) begin
            gap = n_ext;
        end else if (vh > T_MID) begin
            gap = p_half + w2;
        end else if (hv > T_MID) begin
            gap = p_half + n2;
        end else if (vh > T_LO) begin
            gap = p3_q[10:0] + w4;
        end else if (hv > T_LO) begin
            gap = p3_q[10:0] + n4;
        end else begin
            gap = p;
        end

        if (i_pos.first) begin
            o_pred = 11'(dgp_pkg::INIT_PRED);
        end else if (i_pos.row0) begin
            o_pred = w_ext;
        end else if (i_pos.border) begin
            o_pred = n_ext;
        end else begin
            case (i_rule)
                dgp_pkg::RULE_WEST:  o_pred = w_ext;
                dgp_pkg::RULE_NORTH: o_pred = n_ext;
                dgp_pkg::RULE_MEAN:  o_pred = w2 + n2;
                default:             o_pred = gap;
            endcase
        end
    end

endmodule

[hw/rtl/dpcm_gap_pixel_predictor_unit.sv]
// channel   dir  handshake                     payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata[7:0] pixel
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata[9:0] pred_error, tlast end_of_frame
// apb       in   psel/penable/pwrite/pready    image_width, image_height, prediction_rule
//
// one item per clock sustained while m_axis_tready stays high; an accepted item is held in the
// input register and then the output register; line buffer reads are issued at input accept,
// the prediction runs between the input register and the output register
// synchronous reset clears the configuration, the indices and the west registers;
// line buffers are not cleared
// a stall on m_axis holds the input stage and the line buffer read data; s_axis_tready
// drops only when both stages are full and stalled
module dpcm_gap_pixel_predictor_unit #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] pixel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [9:0] pred_error, [15:10] zero
    output logic        m_axis_tlast
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int LW = (AW + 1 > dgp_pkg::CFG_W_W) ? AW + 1 : dgp_pkg::CFG_W_W;
    localparam logic [LW-1:0] MAX_W    = LW'(MAX_WIDTH);
    localparam logic [LW-1:0] MAX_LAST = LW'(MAX_WIDTH - 1);
    localparam logic [LW-1:0] MIN_W    = LW'(dgp_pkg::MIN_WIDTH);
    localparam logic [LW-1:0] MIN_LAST = LW'(dgp_pkg::MIN_WIDTH - 1);
    localparam logic [15:0]   MIN_H    = 16'(dgp_pkg::MIN_HEIGHT);
    localparam logic [15:0]   MIN_HL   = 16'(dgp_pkg::MIN_HEIGHT - 1);

    // configuration
    logic [dgp_pkg::CFG_W_W-1:0] r_cfg_width;
    logic [dgp_pkg::CFG_H_W-1:0] r_cfg_height;
    dgp_pkg::t_rule              r_cfg_rule;
    logic                        cfg_wr;

    // indices
    logic [AW-1:0]  r_col;
    logic [15:0]    r_row;
    logic [AW-1:0]  n_col;
    logic [15:0]    n_row;
    logic [LW-1:0]  width_ext;
    logic [LW-1:0]  last_idx;
    logic [15:0]    h_last;
    logic           last_col;
    logic           last_row;
    logic [AW-1:0]  c_eff;
    logic [AW-1:0]  raddr_b;
    dgp_pkg::t_pos  pos;

    // input stage
    logic           r_s1_valid;
    dgp_pkg::t_pix  r_s1_pix;
    logic [AW-1:0]  r_s1_col;
    dgp_pkg::t_pos  r_s1_pos;
    logic           r_s1_eof;
    logic           s1_adv;
    logic           in_acc;

    // neighbours
    dgp_pkg::t_pix  r_west;
    dgp_pkg::t_pix  r_west2;
    dgp_pkg::t_pix  r_nw;
    dgp_pkg::t_pix  ra_n;
    dgp_pkg::t_pix  ra_ne;
    dgp_pkg::t_pix  r2_nn;
    dgp_pkg::t_pix  r2_nne;
    dgp_pkg::t_nbr  nbr;

    logic signed [dgp_pkg::PRED_W-1:0] pred;
    logic signed [dgp_pkg::PRED_W-1:0] diff;

    // output stage
    logic                      r_out_valid;
    logic [dgp_pkg::ERR_W-1:0] r_out_err;
    logic                      r_out_eof;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= dgp_pkg::RST_WIDTH;
            r_cfg_height <= dgp_pkg::RST_HEIGHT;
            r_cfg_rule   <= dgp_pkg::RULE_GAP;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                dgp_pkg::REG_WIDTH:  r_cfg_width  <= pwdata[dgp_pkg::CFG_W_W-1:0];
                dgp_pkg::REG_HEIGHT: r_cfg_height <= pwdata[dgp_pkg::CFG_H_W-1:0];
                dgp_pkg::REG_RULE:   r_cfg_rule   <= dgp_pkg::t_rule'(pwdata[1:0]);
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            dgp_pkg::REG_WIDTH:  prdata = 32'(r_cfg_width);
            dgp_pkg::REG_HEIGHT: prdata = 32'(r_cfg_height);
            dgp_pkg::REG_RULE:   prdata = 32'(r_cfg_rule);
            default:             prdata = '0;
        endcase
    end

    // ---------------- position and line buffer addressing ----------------
    always_comb begin
        width_ext = LW'(r_cfg_width);
        if (width_ext < MIN_W) begin
            last_idx = MIN_LAST;
        end else if (width_ext > MAX_W) begin
            last_idx = MAX_LAST;
        end else begin
            last_idx = width_ext - 1'b1;
        end
        h_last   = (r_cfg_height < MIN_H) ? MIN_HL : r_cfg_height - 1'b1;

        // an index at or past the last one counts as the last one
        last_col = (LW'(r_col) >= last_idx);
        last_row = (r_row >= h_last);
        c_eff    = last_col ? last_idx[AW-1:0] : r_col;
        raddr_b  = last_col ? '0 : AW'(c_eff + 1'b1);

        pos.first  = (r_row == '0) && (c_eff == '0);
        pos.row0   = (r_row == '0);
        pos.border = (r_row == 16'd1) || (c_eff < AW'(2)) || last_col;

        if (last_col) begin
            n_col = '0;
            n_row = last_row ? '0 : r_row + 1'b1;
        end else begin
            n_col = AW'(c_eff + 1'b1);
            n_row = r_row;
        end
    end

    assign s1_adv        = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || s1_adv;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_acc) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // ---------------- input stage ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_pix <= s_axis_tdata;
            r_s1_col <= c_eff;
            r_s1_pos <= pos;
            r_s1_eof <= last_col && last_row;
        end
    end

    // line buffers: read at accept, written as the item leaves the input stage
    dgp_ram #(
        .WIDTH (dgp_pkg::PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_row_above (
        .i_clk     (i_clk),
        .i_we      (s1_adv),
        .i_waddr   (r_s1_col),
        .i_wdata   (r_s1_pix),
        .i_re      (in_acc),
        .i_raddr_a (c_eff),
        .i_raddr_b (raddr_b),
        .o_rdata_a (ra_n),
        .o_rdata_b (ra_ne)
    );

    dgp_ram #(
        .WIDTH (dgp_pkg::PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_row_two_above (
        .i_clk     (i_clk),
        .i_we      (s1_adv),
        .i_waddr   (r_s1_col),
        .i_wdata   (ra_n),
        .i_re      (in_acc),
        .i_raddr_a (c_eff),
        .i_raddr_b (raddr_b),
        .o_rdata_a (r2_nn),
        .o_rdata_b (r2_nne)
    );

    // west and north-west follow the item leaving the input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_west  <= '0;
            r_west2 <= '0;
            r_nw    <= '0;
        end else if (s1_adv) begin
            r_west  <= r_s1_pix;
            r_west2 <= r_west;
            r_nw    <= ra_n;
        end
    end

    assign nbr.w   = r_west;
    assign nbr.n   = ra_n;
    assign nbr.ww  = r_west2;
    assign nbr.nw  = r_nw;
    assign nbr.nn  = r2_nn;
    assign nbr.ne  = ra_ne;
    assign nbr.nne = r2_nne;

    dgp_predict u_predict (
        .i_nbr  (nbr),
        .i_pos  (r_s1_pos),
        .i_rule (r_cfg_rule),
        .o_pred (pred)
    );

    assign diff = pred - $signed({3'b000, r_s1_pix});

    // ---------------- output stage ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_err <= diff[dgp_pkg::ERR_W-1:0];
            r_out_eof <= r_s1_eof;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = 16'(r_out_err);
    assign m_axis_tlast  = r_out_eof;

    // ---------------- assertions ----------------
    a_no_accept_when_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted while both stages are full and stalled");

    a_adv_fills_output : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv |=> r_out_valid)
        else $error("item left input stage but output is empty");

    a_frame_wrap : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && last_col && last_row) |=> (r_col == '0 && r_row == '0))
        else $error("indices did not return to origin after last pixel");

    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_s1_valid && !r_out_valid))
        else $error("pipeline not empty after reset");

endmodule
